// ===== hdl/bba_pkg.sv =====
// Shared types, sizes and helpers for the bitmap block allocator.
// No dependencies; imported by the allocator and its test.
package bba_pkg;

	localparam int GROUPS       = 8;
	localparam int BLOCK_BYTES  = 1024;
	localparam int GRP_W        = $clog2(GROUPS);
	localparam int BYTE_W       = $clog2(BLOCK_BYTES);
	localparam int ADDR_W       = GRP_W + BYTE_W;
	localparam int BMAP_DEPTH   = GROUPS * BLOCK_BYTES;

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 14;

	localparam logic [7:0] BYTE_FULL = 8'hff;

	typedef enum logic [1:0] {
		FUNC_LOAD_BYTE = 2'd0,
		FUNC_LOAD_FREE = 2'd1,
		FUNC_ALLOC     = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GROUP_COUNT      = 2'd0,
		REG_BITMAP_BYTES     = 2'd1,
		REG_BLOCKS_PER_GROUP = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} st_t;

	// position of the lowest clear bit; caller guarantees one exists
	function automatic logic [2:0] first_zero(input logic [7:0] b);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!b[i])
				pos = 3'(i);
		end
		return pos;
	endfunction

endpackage

// ===== hdl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator: sequencer, scan counters and free counts.
// Depends on bba_pkg and bba_ram.
//
// Loads (bitmap byte or group free count) keep busy low; the result strobe
// (done, all fields zero) follows in the next cycle. An allocate holds busy
// while the scan reads the bitmap bytes in order up to the first one with a
// clear bit, over at most min(group_count,8) groups of min(bitmap_bytes,1024)
// bytes. The bitmap RAM has one read port and the scan reads one byte a cycle
// through it; a single adder steps the group base block number. done is high
// for exactly one cycle per result and the receiver cannot stall it.
module bitmap_block_allocator
	import bba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            func,
	input  logic [2:0]            group_index,
	input  logic [9:0]            byte_index,
	input  logic [15:0]           load_value,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [15:0]           block_number,
	output logic                  found,
	output logic [15:0]           group_free
);

	st_t state_q, state_d;

	logic [3:0]  group_count_q;
	logic [10:0] bitmap_bytes_q;
	logic [13:0] blocks_per_group_q;

	logic [15:0] free_q [GROUPS];

	logic              issue_q;
	logic [GRP_W-1:0]  g_q;
	logic [BYTE_W-1:0] j_q;
	logic [15:0]       base_q;

	logic              rd_v_s1;
	logic [GRP_W-1:0]  g_s1;
	logic [BYTE_W-1:0] j_s1;
	logic [15:0]       base_s1;

	logic        done_q, found_q;
	logic [15:0] block_number_q, group_free_q;

	logic [7:0]        rd_data;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;

	logic              accept;
	func_t             func_c;
	logic [GRP_W-1:0]  ng_last;
	logic [BYTE_W-1:0] nb_last;
	logic              scan_empty;
	logic              hit;
	logic              miss_end;
	logic [2:0]        bit_k;
	logic [15:0]       blk;
	logic [15:0]       fc_dec;

	assign accept = start && !busy;
	assign func_c = func_t'(func);
	assign busy   = (state_q != ST_IDLE);

	// limits clamped to the storage size; zero scans nothing
	always_comb begin
		ng_last    = (32'(group_count_q) > GROUPS) ? GRP_W'(GROUPS - 1)
		                                             : GRP_W'(group_count_q - 4'd1);
		nb_last    = (32'(bitmap_bytes_q) > BLOCK_BYTES) ? BYTE_W'(BLOCK_BYTES - 1)
		                                                    : BYTE_W'(bitmap_bytes_q - 11'd1);
		scan_empty = (group_count_q == 4'd0) || (bitmap_bytes_q == 11'd0);
	end

	assign hit      = (state_q == ST_SCAN) && rd_v_s1 && (rd_data != BYTE_FULL);
	assign miss_end = (state_q == ST_SCAN) && !rd_v_s1 && !issue_q;
	assign bit_k    = first_zero(rd_data);
	assign blk      = base_s1 + 16'({j_s1, 3'b000}) + 16'(bit_k);
	assign fc_dec   = free_q[g_s1] - 16'd1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {group_index, byte_index};
		ram_wdata = load_value[7:0];
		if (hit) begin
			ram_we    = 1'b1;
			ram_waddr = {g_s1, j_s1};
			ram_wdata = rd_data | (8'b1 << bit_k);
		end else if (accept && func_c == FUNC_LOAD_BYTE &&
		             32'(group_index) < GROUPS && 32'(byte_index) < BLOCK_BYTES) begin
			ram_we = 1'b1;
		end
	end

	bba_ram #(
		.DEPTH (BMAP_DEPTH),
		.WIDTH (8)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr ({g_q, j_q}),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func_c == FUNC_ALLOC)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit || miss_end)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q      <= 4'd1;
			bitmap_bytes_q     <= 11'd1024;
			blocks_per_group_q <= 14'd8192;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROUP_COUNT:      group_count_q      <= cfg_data[3:0];
				REG_BITMAP_BYTES:     bitmap_bytes_q     <= cfg_data[10:0];
				REG_BLOCKS_PER_GROUP: blocks_per_group_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// free counts: contents undefined until loaded
	always_ff @(posedge clk) begin
		if (hit)
			free_q[g_s1] <= fc_dec;
		else if (accept && func_c == FUNC_LOAD_FREE && 32'(group_index) < GROUPS)
			free_q[GRP_W'(group_index)] <= load_value;
	end

	// scan address walk: bytes within a group, then next group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			g_q     <= '0;
			j_q     <= '0;
			base_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			g_q     <= '0;
			j_q     <= '0;
			base_q  <= '0;
			rd_v_s1 <= 1'b0;
			issue_q <= accept && func_c == FUNC_ALLOC && !scan_empty;
		end else if (hit || miss_end) begin
			issue_q <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue_q;
			if (issue_q) begin
				if (j_q == nb_last) begin
					j_q <= '0;
					if (g_q == ng_last) begin
						issue_q <= 1'b0;
					end else begin
						g_q    <= g_q + GRP_W'(1);
						base_q <= base_q + 16'(blocks_per_group_q);
					end
				end else begin
					j_q <= j_q + BYTE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		g_s1    <= g_q;
		j_s1    <= j_q;
		base_s1 <= base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (accept && func_c != FUNC_ALLOC) || hit || miss_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q        <= 1'b0;
			block_number_q <= '0;
			group_free_q   <= '0;
		end else if (hit) begin
			found_q        <= 1'b1;
			block_number_q <= blk;
			group_free_q   <= fc_dec;
		end else begin
			found_q        <= 1'b0;
			block_number_q <= '0;
			group_free_q   <= '0;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign block_number = block_number_q;
	assign group_free   = group_free_q;

`ifndef ASSERT_OFF
	a_found_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> done_q)
		else $error("found without result strobe");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (block_number_q == 16'd0 && group_free_q == 16'd0))
		else $error("non-zero fields on empty result");

	a_scan_write_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ram_we) |-> hit)
		else $error("bitmap write during scan without a hit");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_v_s1)
		else $error("read pending while idle");

	a_alloc_ends_in_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && state_d == ST_IDLE) |=> done_q)
		else $error("allocate finished without a result");
`endif

endmodule

// ===== verif/bitmap_block_allocator_test.sv =====
// Self-checking test of bitmap_block_allocator: loads, allocates and register settings,
// predicted in a scoreboard class and compared field by field with each done strobe.
// Depends on bba_pkg and the allocator RTL only.
module bitmap_block_allocator_test;
	import bba_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic [15:0] blk;
		logic        fnd;
		logic [15:0] gfree;
	} alloc_result_t;

	typedef enum int {
		FOUND_BIT,
		NO_FREE_BIT,
		NEED_BYTE,
		NEED_COUNT
	} scan_outcome_t;

	class bitmap_tracker;
		logic [7:0]    bmap [BMAP_DEPTH];
		bit            byte_loaded [BMAP_DEPTH];
		logic [15:0]   free_cnt [GROUPS];
		bit            count_loaded [GROUPS];
		logic [3:0]    group_cnt = 4'd1;
		logic [10:0]   scan_bytes = 11'd1024;
		logic [13:0]   blocks_per_grp = 14'd8192;
		alloc_result_t pending [$];
		int            errors = 0;

		function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_GROUP_COUNT:      group_cnt = d[3:0];
				REG_BITMAP_BYTES:     scan_bytes = d[10:0];
				REG_BLOCKS_PER_GROUP: blocks_per_grp = d[13:0];
				default: ;
			endcase
		endfunction

		function void scan_limits(output int ng, output int nb);
			ng = (group_cnt < GROUPS) ? int'(group_cnt) : GROUPS;
			nb = (scan_bytes < BLOCK_BYTES) ? int'(scan_bytes) : BLOCK_BYTES;
		endfunction

		// walks the scan path; stops early on a byte or count never loaded
		function scan_outcome_t locate_free_bit(output int g, output int j, output int k);
			int ng, nb, a;
			scan_limits(ng, nb);
			g = 0;
			j = 0;
			k = 0;
			for (g = 0; g < ng; g++) begin
				for (j = 0; j < nb; j++) begin
					a = g * BLOCK_BYTES + j;
					if (!byte_loaded[a])
						return NEED_BYTE;
					if (bmap[a] != BYTE_FULL) begin
						k = 0;
						while (bmap[a][k])
							k++;
						return count_loaded[g] ? FOUND_BIT : NEED_COUNT;
					end
				end
			end
			return NO_FREE_BIT;
		endfunction

		function void note_request(logic [1:0] f, logic [2:0] g, logic [9:0] b,
				logic [15:0] v);
			alloc_result_t res;
			scan_outcome_t st;
			int sg, sj, sk, blk;
			res = '0;
			case (f)
				FUNC_LOAD_BYTE: begin
					bmap[int'(g) * BLOCK_BYTES + int'(b)] = v[7:0];
					byte_loaded[int'(g) * BLOCK_BYTES + int'(b)] = 1'b1;
				end
				FUNC_LOAD_FREE: begin
					free_cnt[g] = v;
					count_loaded[g] = 1'b1;
				end
				FUNC_ALLOC: begin
					st = locate_free_bit(sg, sj, sk);
					if (st == FOUND_BIT) begin
						bmap[sg * BLOCK_BYTES + sj][sk] = 1'b1;
						free_cnt[sg] = free_cnt[sg] - 16'd1;
						blk = sg * int'(blocks_per_grp) + sj * 8 + sk;
						res.blk = blk[15:0];
						res.fnd = 1'b1;
						res.gfree = free_cnt[sg];
					end
				end
				default: ;
			endcase
			pending.push_back(res);
		endfunction

		function void check_result(logic [15:0] blk, logic fnd, logic [15:0] gfree);
			alloc_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: block_number %0d found %0b group_free %0d",
						blk, fnd, gfree);
				return;
			end
			want = pending.pop_front();
			if (want.blk !== blk || want.fnd !== fnd || want.gfree !== gfree) begin
				errors++;
				if (errors <= 10)
					$display("mismatch (exp/got): block %0d/%0d found %0b/%0b free %0d/%0d",
						want.blk, blk, want.fnd, fnd, want.gfree, gfree);
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            func = '0;
	logic [2:0]            group_index = '0;
	logic [9:0]            byte_index = '0;
	logic [15:0]           load_value = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic [15:0]           block_number;
	logic                  found;
	logic [15:0]           group_free;

	bitmap_tracker track = new();
	int burst_left = 0;

	bitmap_block_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.group_index  (group_index),
		.byte_index   (byte_index),
		.load_value   (load_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.block_number (block_number),
		.found        (found),
		.group_free   (group_free)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			track.check_result(block_number, found, group_free);
	end

	// start is left high on acceptance; the next request or a gap decides its value
	task automatic send_request(input logic [1:0] f, input logic [2:0] g,
			input logic [9:0] b, input logic [15:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		func <= f;
		group_index <= g;
		byte_index <= b;
		load_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track.note_request(f, g, b, v);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		burst_left = 0;
		while (track.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		track.write_register(idx, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits are filled at random
	task automatic configure(input logic [3:0] gc, input logic [10:0] bb,
			input logic [13:0] bpg);
		write_register(REG_GROUP_COUNT, {10'($urandom), gc});
		write_register(REG_BITMAP_BYTES, {3'($urandom), bb});
		write_register(REG_BLOCKS_PER_GROUP, bpg);
	endtask

	task automatic random_request();
		scan_outcome_t st;
		int sg, sj, sk, ng, nb, pick, r;
		logic [7:0] bval;
		logic [15:0] cnt;
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, 3);
		cnt = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : (r == 2) ? 16'h0001 : 16'($urandom);
		track.scan_limits(ng, nb);
		if (pick < 55) begin
			// an allocate goes out only once its whole scan path has been loaded
			st = track.locate_free_bit(sg, sj, sk);
			case (st)
				NEED_BYTE: begin
					bval = ($urandom_range(0, 9) < 6) ? BYTE_FULL : 8'($urandom);
					send_request(FUNC_LOAD_BYTE, 3'(sg), 10'(sj), {8'($urandom), bval});
				end
				NEED_COUNT:
					send_request(FUNC_LOAD_FREE, 3'(sg), 10'($urandom), cnt);
				default:
					send_request(FUNC_ALLOC, 3'($urandom), 10'($urandom), 16'($urandom));
			endcase
		end else if (pick < 72) begin
			// refill a byte near the front of the scanned area
			sg = $urandom_range(0, (ng > 0) ? ng - 1 : 7);
			sj = $urandom_range(0, ((nb > 16) ? 16 : (nb > 0) ? nb : 1) - 1);
			send_request(FUNC_LOAD_BYTE, 3'(sg), 10'(sj), 16'($urandom));
		end else if (pick < 80) begin
			send_request(FUNC_LOAD_FREE, 3'($urandom), 10'($urandom), cnt);
		end else if (pick < 95) begin
			send_request(FUNC_LOAD_BYTE, 3'($urandom), 10'($urandom), 16'($urandom));
		end else begin
			send_request(FUNC_SPARE, 3'($urandom), 10'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int p, n, r;
		logic [3:0] gc;
		logic [10:0] bb;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all groups full but the last, whose block number overflows 16 bits
		configure(4'd8, 11'd1, 14'd16383);
		send_request(FUNC_SPARE, 3'h7, 10'h3ff, 16'hffff);
		for (n = 0; n < 7; n++)
			send_request(FUNC_LOAD_BYTE, 3'(n), 10'd0, {8'(n * 37), BYTE_FULL});
		send_request(FUNC_LOAD_BYTE, 3'd7, 10'd0, 16'hff7f);
		send_request(FUNC_LOAD_FREE, 3'd7, 10'd0, 16'h0000);
		send_request(FUNC_ALLOC, 3'd0, 10'd0, 16'd0);
		send_request(FUNC_ALLOC, 3'h7, 10'h3ff, 16'hffff);
		wait_idle();

		// zero group count and zero byte count scan nothing
		configure(4'd0, 11'd1, 14'd16383);
		send_request(FUNC_ALLOC, 3'd0, 10'd0, 16'd0);
		wait_idle();
		configure(4'd15, 11'd0, 14'd16383);
		send_request(FUNC_ALLOC, 3'd0, 10'd0, 16'd0);
		wait_idle();

		// oversized byte count, zero blocks per group
		configure(4'd15, 11'd2047, 14'd0);
		send_request(FUNC_LOAD_BYTE, 3'd0, 10'd1, 16'h5a00);
		send_request(FUNC_LOAD_FREE, 3'd0, 10'd0, 16'hffff);
		send_request(FUNC_ALLOC, 3'd0, 10'd0, 16'd0);
		send_request(FUNC_LOAD_BYTE, 3'd7, 10'h3ff, 16'h8000);
		send_request(FUNC_ALLOC, 3'd0, 10'd0, 16'd0);
		wait_idle();

		for (p = 0; p < 7; p++) begin
			case (p)
				0: configure(4'd8, 11'd1024, 14'd8192);
				1: configure(4'd1, 11'd1, 14'd1);
				default: begin
					gc = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom);
					r = $urandom_range(0, 19);
					bb = (r < 14) ? 11'($urandom_range(1, 8)) :
						(r < 18) ? 11'($urandom_range(9, 64)) : 11'($urandom);
					configure(gc, bb, 14'($urandom));
				end
			endcase
			for (n = 0; n < 80; n++) begin
				random_request();
				if ($urandom_range(0, 49) == 0)
					wait_idle();
			end
			wait_idle();
		end

		repeat (16) @(posedge clk);
		if (track.errors == 0 && track.outstanding() == 0)
			$display("** bitmap_block_allocator: PASSED **");
		else
			$display("** bitmap_block_allocator: FAILED **");
		$finish;
	end

	initial begin
		#4000000;
		$display("** bitmap_block_allocator: FAILED **");
		$finish;
	end

endmodule
